// ===== hw/rtl/stepped_cascade_lowpass_core_defines.svh =====
// Assertion helpers used by the checker of the lowpass core.
`ifndef STEPPED_CASCADE_LOWPASS_CORE_DEFINES_SVH
`define STEPPED_CASCADE_LOWPASS_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define SCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/scl_pkg.sv =====
package scl_pkg;

  // Configuration register indexes
  localparam logic [1:0] RegListenChannel  = 2'd0;
  localparam logic [1:0] RegStepLevels     = 2'd1;
  localparam logic [1:0] RegPhaseIncrement = 2'd2;
  localparam logic [1:0] RegPhasePeriod    = 2'd3;

  localparam logic OpcodeTick   = 1'b0;
  localparam logic OpcodeNoteOn = 1'b1;

  typedef enum logic [2:0] {
    OP_WAIT,   // idle, take the next transaction
    OP_PHASE,  // advance phase and step, load coefficient
    OP_MUL,    // product of stage difference and coefficient
    OP_ACC,    // fold product into the stage
    OP_EMIT    // fold product into the last stage and issue the result
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] sel;
    logic [2:0] nxt;
  } ucode_t;

  typedef struct packed {
    op_e        op;
    logic [1:0] sel;
    logic       go;
  } dp_ctrl_t;

  typedef struct packed {
    logic tick_take;
    logic out_free;
  } seq_status_t;

  localparam int unsigned UcodeDepth = 8;

  localparam ucode_t Ucode [UcodeDepth] = '{
    '{OP_WAIT,  2'd0, 3'd1},
    '{OP_PHASE, 2'd0, 3'd2},
    '{OP_MUL,   2'd0, 3'd3},
    '{OP_ACC,   2'd0, 3'd4},
    '{OP_MUL,   2'd1, 3'd5},
    '{OP_ACC,   2'd1, 3'd6},
    '{OP_MUL,   2'd2, 3'd7},
    '{OP_EMIT,  2'd2, 3'd0}
  };

  // Q16 coefficient for level L: round(L * 65536 / 30)
  localparam logic [15:0] CoefTable [16] = '{
    16'd0,     16'd2185,  16'd4369,  16'd6554,
    16'd8738,  16'd10923, 16'd13107, 16'd15292,
    16'd17476, 16'd19661, 16'd21845, 16'd24030,
    16'd26214, 16'd28399, 16'd30583, 16'd32768
  };

endpackage

// ===== hw/rtl/scl_if.sv =====
interface scl_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] sample_in;
  logic [3:0]  event_channel;

  modport source (output valid, output opcode, output sample_in, output event_channel,
                  input ready);
  modport sink (input valid, input opcode, input sample_in, input event_channel,
                output ready);
endinterface

interface scl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface scl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/scl_ucode_seq.sv =====
module scl_ucode_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scl_pkg::seq_status_t status_i,
  output scl_pkg::dp_ctrl_t    ctrl_o
);
  import scl_pkg::*;

  logic [2:0] upc_q, upc_d;
  ucode_t     word;
  logic       go;

  assign word = Ucode[upc_q];

  always_comb begin
    unique case (word.op)
      OP_WAIT: go = status_i.tick_take;
      OP_EMIT: go = status_i.out_free;
      default: go = 1'b1;
    endcase
    upc_d = go ? word.nxt : upc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= '0;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = '{op: word.op, sel: word.sel, go: go};

endmodule

// ===== hw/rtl/scl_filter_dp.sv =====
module scl_filter_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scl_pkg::dp_ctrl_t  ctrl_i,
  input  logic               load_i,
  input  logic [15:0]        sample_top_i,
  input  logic [15:0]        coef_i,
  output logic [31:0]        sample_out_o
);
  import scl_pkg::*;

  logic signed [31:0] st_q [3];
  logic signed [31:0] chain_q;
  logic signed [49:0] prod_q;

  logic signed [31:0] st_cur;
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic signed [49:0] prod_adj;
  logic signed [49:0] prod_shr;
  logic signed [31:0] st_new;
  logic signed [32:0] out_adj;
  logic signed [32:0] out_shr;

  assign st_cur = st_q[ctrl_i.sel];
  assign diff   = {chain_q[31], chain_q} - {st_cur[31], st_cur};
  assign prod   = diff * $signed({1'b0, coef_i});

  // Shift right by 16 rounding toward zero
  assign prod_adj = prod_q + (prod_q[49] ? 50'sd65535 : 50'sd0);
  assign prod_shr = prod_adj >>> 16;
  assign st_new   = st_cur + prod_shr[31:0];

  assign out_adj = {st_new[31], st_new} + (st_new[31] ? 33'sd65535 : 33'sd0);
  assign out_shr = out_adj >>> 16;
  assign sample_out_o = {out_shr[15:0], 16'h0000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q[0] <= '0;
      st_q[1] <= '0;
      st_q[2] <= '0;
    end else if ((ctrl_i.op == OP_ACC) || (ctrl_i.op == OP_EMIT && ctrl_i.go)) begin
      st_q[ctrl_i.sel] <= st_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      chain_q <= {sample_top_i, 16'h0000};
    end else if (ctrl_i.op == OP_ACC) begin
      chain_q <= st_new;
    end
    if (ctrl_i.op == OP_MUL) begin
      prod_q <= prod;
    end
  end

endmodule

// ===== hw/rtl/stepped_cascade_lowpass_core.sv =====
// Stepped three-stage lowpass core.
//
// in_i carries transactions: opcode 0 is a sample tick, opcode 1 a note-on on
// event_channel. A note-on on the listened channel restarts the step
// sequence and gives no result. A tick gives one result
// on out_o, filtered through three one-pole stages whose shared coefficient
// comes from the current step level.
// cfg_i writes a register by index (0 listen channel, 1 step levels,
// 2 phase increment, 3 phase period); it is always ready.
// A tick occupies the block for its accept cycle and a 7-step
// microprogram (phase update, then multiply and accumulate for each stage).
// The stages share a single multiplier. out_o.valid rises once the last
// step issues the result; in_i.ready is low while the program runs.
// A finished result waits in the output register while the next transaction
// is accepted; if it still waits when the next result is ready the program
// holds on its last step until out_o.ready.
// Reset idles the sequence, zeros the stages and loads register defaults.
module stepped_cascade_lowpass_core #(
  parameter int unsigned STEPS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  scl_in_if.sink         in_i,
  scl_out_if.source      out_o,
  scl_cfg_if.sink        cfg_i
);
  import scl_pkg::*;

  localparam logic [3:0] StepsEnd = 4'(STEPS);

  logic [3:0]  listen_q;
  logic [31:0] levels_q;
  logic [15:0] incr_q;
  logic [19:0] period_q;

  logic        active_q, active_d;
  logic [2:0]  step_q, step_d;
  logic [20:0] phase_q, phase_d;
  logic [15:0] coef_q, coef_d;

  logic        out_valid_q;
  logic [31:0] out_data_q;

  dp_ctrl_t    ctrl;
  seq_status_t status;
  logic        in_take;
  logic        tick_take;
  logic        emit;
  logic [31:0] dp_sample;

  logic [21:0] sum;
  logic [21:0] sum_wrap;
  logic        wrap;
  logic [3:0]  idx;
  logic [3:0]  level;

  assign in_i.ready  = (ctrl.op == OP_WAIT);
  assign cfg_i.ready = 1'b1;
  assign in_take     = in_i.valid && in_i.ready;
  assign tick_take   = in_take && (in_i.opcode == OpcodeTick);
  assign emit        = (ctrl.op == OP_EMIT) && ctrl.go;

  assign status = '{tick_take: tick_take, out_free: !out_valid_q || out_o.ready};

  scl_ucode_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  scl_filter_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .load_i       (tick_take),
    .sample_top_i (in_i.sample_in[31:16]),
    .coef_i       (coef_q),
    .sample_out_o (dp_sample)
  );

  // Phase advance, at most one wrap per tick
  assign sum      = {1'b0, phase_q} + {6'd0, incr_q};
  assign wrap     = sum > {2'b00, period_q};
  assign sum_wrap = sum - {2'b00, period_q};
  assign idx      = {1'b0, step_q} + {3'd0, wrap};

  always_comb begin
    active_d = active_q;
    step_d   = step_q;
    phase_d  = phase_q;
    coef_d   = coef_q;
    level    = levels_q[{step_q, 2'b00} +: 4];
    if (in_take && (in_i.opcode == OpcodeNoteOn) && (in_i.event_channel == listen_q)) begin
      active_d = 1'b1;
      step_d   = '0;
      phase_d  = '0;
    end else if (ctrl.op == OP_PHASE) begin
      if (active_q) begin
        phase_d = wrap ? sum_wrap[20:0] : sum[20:0];
        if (idx >= StepsEnd) begin
          active_d = 1'b0;
          step_d   = '0;
        end else begin
          step_d = idx[2:0];
        end
      end
      level  = levels_q[{step_d, 2'b00} +: 4];
      coef_d = active_d ? CoefTable[level] : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q <= '0;
      levels_q <= '0;
      incr_q   <= 16'd50;
      period_q <= 20'd100000;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        RegListenChannel:  listen_q <= cfg_i.data[3:0];
        RegStepLevels:     levels_q <= cfg_i.data;
        RegPhaseIncrement: incr_q   <= cfg_i.data[15:0];
        RegPhasePeriod:    period_q <= cfg_i.data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      step_q      <= '0;
      phase_q     <= '0;
      coef_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      step_q   <= step_d;
      phase_q  <= phase_d;
      coef_q   <= coef_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= dp_sample;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

endmodule

// ===== hw/rtl/scl_checker.sv =====
`include "stepped_cascade_lowpass_core_defines.svh"

module scl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_opcode_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_sample_i
);
  import scl_pkg::*;

  // A tick transaction blocks the input while the program runs
  `SCL_ASSERT_NEXT(a_tick_busy, in_valid_i && in_ready_i && (in_opcode_i == OpcodeTick), !in_ready_i, "input ready right after a tick")

  // A result is only issued from the busy program
  `SCL_ASSERT(a_result_from_program, $rose(out_valid_i) |-> !$past(in_ready_i), "result while idle")

  // A stalled result holds
  `SCL_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_sample_i), "stalled result changed")

  // Low half of the result is always zero
  `SCL_ASSERT(a_low_zero, out_valid_i |-> (out_sample_i[15:0] == 16'h0000), "low bits not zero")

endmodule

bind stepped_cascade_lowpass_core scl_checker u_scl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_opcode_i  (in_i.opcode),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample_out)
);
